/* rtl/pws_pkg.sv */
// Package for the perspective world-to-screen block.
// Viewport and layout constants, pipeline latencies, matrix entry mapping.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pws_pkg;

  localparam int VIEW_WIDTH       = 1920;
  localparam int VIEW_HEIGHT      = 1080;
  localparam int ROW_MAJOR_LAYOUT = 0;

  localparam int REG_COUNT = 8;
  localparam int CFG_IDX_W = 4;
  localparam int VW_W      = 15;

  localparam logic [VW_W-1:0] VIEW_W_C = VW_W'(VIEW_WIDTH);
  localparam logic [VW_W-1:0] VIEW_H_C = VW_W'(VIEW_HEIGHT);

  localparam logic signed [31:0] NEAR_LIMIT = 32'sd6554;
  localparam logic signed [31:0] Q16_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q16_MIN    = 32'sh8000_0000;

  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int PIPE_LAT  = DIV_LAT + 4;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_W = 2;

  // Matrix entry used by clip row r and coordinate column c (c = 3: translation).
  function automatic logic [3:0] ent_idx(input int r, input int c);
    logic [3:0] idx;
    if (ROW_MAJOR_LAYOUT != 0) begin
      idx = 4'((r * 4) + c);
    end else begin
      idx = 4'((c * 4) + ((r == ROW_W) ? 3 : r));
    end
    return idx;
  endfunction

  function automatic logic [63:0] mat_reset(input int i);
    logic [63:0] v;
    case (i)
      0:       v = 64'h0000_0000_0001_0000;
      2:       v = 64'h0001_0000_0000_0000;
      5:       v = 64'h0000_0000_0001_0000;
      7:       v = 64'h0001_0000_0000_0000;
      default: v = 64'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/pws_div.sv */
// Pipelined restoring divider, one quotient bit per stage, floor rounding
// with sign and saturation to signed 32 bits. Depends on pws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pws_div (
  input  wire logic        clk_i,
  input  wire logic [62:0] num_i,
  input  wire logic [30:0] den_i,
  input  wire logic        neg_i,
  output logic      [31:0] quo_o
);

  localparam int N = pws_pkg::DIV_STEPS;

  logic [30:0] r_q   [0:N];
  logic [31:0] lo_q  [0:N];
  logic [30:0] d_q   [0:N];
  logic [31:0] q_q   [0:N];
  logic        neg_q [0:N];
  logic        ovf_q [0:N];

  always_ff @(posedge clk_i) begin
    r_q[0]   <= num_i[62:32];
    lo_q[0]  <= num_i[31:0];
    d_q[0]   <= den_i;
    q_q[0]   <= '0;
    neg_q[0] <= neg_i;
    ovf_q[0] <= (num_i[62:32] >= den_i);
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [31:0] rin;
    logic [31:0] diff;
    logic        ge;
    assign rin  = {r_q[k], lo_q[k][31]};
    assign diff = rin - {1'b0, d_q[k]};
    assign ge   = (rin >= {1'b0, d_q[k]});
    always_ff @(posedge clk_i) begin
      r_q[k+1]   <= ge ? diff[30:0] : rin[30:0];
      lo_q[k+1]  <= {lo_q[k][30:0], 1'b0};
      d_q[k+1]   <= d_q[k];
      q_q[k+1]   <= {q_q[k][30:0], ge};
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  logic [32:0] mag;
  logic [31:0] quo_d;

  always_comb begin
    mag = {1'b0, q_q[N]} + {32'h0, (r_q[N] != '0)};
    if (neg_q[N]) begin
      if (ovf_q[N] || (mag > 33'h0_8000_0000)) begin
        quo_d = pws_pkg::Q16_MIN;
      end else begin
        quo_d = 32'(~mag + 33'd1);
      end
    end else begin
      if (ovf_q[N] || q_q[N][31]) begin
        quo_d = pws_pkg::Q16_MAX;
      end else begin
        quo_d = q_q[N];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_o <= quo_d;
  end

endmodule
`default_nettype wire

/* rtl/perspective_world_to_screen.sv */
// Top level: matrix registers, clip transform pipeline and screen mapping.
// Depends on pws_pkg and pws_div.
//
// channel  | handshake                 | payload
// point    | start_i, busy_o           | point_x_i, point_y_i, point_z_i
// result   | valid_o (one-cycle beat)  | visible_o, screen_x_o, screen_y_o
// config   | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One point per cycle; results come out in the order of their start beats.
// The divider has 32 stages, one quotient bit per stage.
// busy_o and cfg_ready_o are constant: the pipeline never stalls.
// Reset loads the identity matrix and clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module perspective_world_to_screen (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic signed [31:0]                 point_x_i,
  input  wire logic signed [31:0]                 point_y_i,
  input  wire logic signed [31:0]                 point_z_i,
  output logic                                    valid_o,
  output logic                                    visible_o,
  output logic signed [31:0]                      screen_x_o,
  output logic signed [31:0]                      screen_y_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [pws_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [63:0]                        cfg_data_i
);

  localparam int NR = pws_pkg::REG_COUNT;
  localparam int DL = pws_pkg::DIV_LAT;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [63:0] mat_q [0:NR-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NR; i++) begin
        mat_q[i] <= pws_pkg::mat_reset(i);
      end
    end else if (cfg_valid_i && (cfg_index_i < pws_pkg::CFG_IDX_W'(NR))) begin
      mat_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  logic signed [31:0] ent [0:15];
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      ent[k] = (k % 2 == 1) ? mat_q[k / 2][63:32] : mat_q[k / 2][31:0];
    end
  end

  // stage 1: products
  logic signed [31:0] pt [0:2];
  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  logic               v1_q;
  logic signed [63:0] prod_q [0:2][0:2];
  logic signed [31:0] tr1_q  [0:2];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[r][c] <= pt[c] * ent[pws_pkg::ent_idx(r, c)];
      end
      tr1_q[r] <= ent[pws_pkg::ent_idx(r, 3)];
    end
  end

  // stage 2: floor shift and sum
  logic               v2_q;
  logic signed [49:0] sum_q [0:2];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      sum_q[r] <= 50'(signed'(prod_q[r][0][63:16])) + 50'(signed'(prod_q[r][1][63:16]))
                + 50'(signed'(prod_q[r][2][63:16])) + 50'(tr1_q[r]);
    end
  end

  // stage 3: saturate to clip values
  logic               v3_q;
  logic signed [31:0] clip_q [0:2];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      if (sum_q[r] > 50'(pws_pkg::Q16_MAX)) begin
        clip_q[r] <= pws_pkg::Q16_MAX;
      end else if (sum_q[r] < 50'(pws_pkg::Q16_MIN)) begin
        clip_q[r] <= pws_pkg::Q16_MIN;
      end else begin
        clip_q[r] <= sum_q[r][31:0];
      end
    end
  end

  // stage 4: visibility, numerator sign and magnitude, denominator
  logic signed [32:0] cx, cy, cw, ax, ay;
  logic               vis_d;

  always_comb begin
    cx = 33'(clip_q[pws_pkg::ROW_X]);
    cy = 33'(clip_q[pws_pkg::ROW_Y]);
    cw = 33'(clip_q[pws_pkg::ROW_W]);
    ax = cx + cw;
    ay = cw - cy;
    vis_d = (clip_q[pws_pkg::ROW_W] >= pws_pkg::NEAR_LIMIT);
    if (pws_pkg::ROW_MAJOR_LAYOUT != 0) begin
      if (ax < 0 || cx > cw || cy > cw || (cy + cw) < 0) begin
        vis_d = 1'b0;
      end
    end
  end

  logic        v4_q, vis4_q, negx_q, negy_q;
  logic [32:0] magx_q, magy_q;
  logic [30:0] den_q;

  always_ff @(posedge clk_i) begin
    vis4_q <= vis_d;
    negx_q <= ax[32];
    negy_q <= ay[32];
    magx_q <= ax[32] ? 33'(-ax) : 33'(ax);
    magy_q <= ay[32] ? 33'(-ay) : 33'(ay);
    den_q  <= clip_q[pws_pkg::ROW_W][30:0];
  end

  logic [47:0] nx_p, ny_p;
  assign nx_p = 48'(magx_q) * 48'(pws_pkg::VIEW_W_C);
  assign ny_p = 48'(magy_q) * 48'(pws_pkg::VIEW_H_C);

  logic [31:0] qx, qy;

  pws_div u_div_x (
    .clk_i (clk_i),
    .num_i ({nx_p, 15'h0}),
    .den_i (den_q),
    .neg_i (negx_q),
    .quo_o (qx)
  );

  pws_div u_div_y (
    .clk_i (clk_i),
    .num_i ({ny_p, 15'h0}),
    .den_i (den_q),
    .neg_i (negy_q),
    .quo_o (qy)
  );

  logic [DL-1:0] vl_q;
  logic [DL-1:0] visl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vl_q <= '0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vl_q <= {vl_q[DL-2:0], v4_q};
    end
  end

  always_ff @(posedge clk_i) begin
    visl_q <= {visl_q[DL-2:0], vis4_q};
  end

  assign valid_o    = vl_q[DL-1];
  assign visible_o  = visl_q[DL-1];
  assign screen_x_o = visl_q[DL-1] ? qx : '0;
  assign screen_y_o = visl_q[DL-1] ? qy : '0;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(pws_pkg::PIPE_LAT) valid_o)
    else $error("result beat missing after fixed latency");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !visible_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("rejected point carries nonzero screen value");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> $past(v3_q) && $past(v2_q, 2))
    else $error("valid bit broke from pipeline order");

endmodule
`default_nettype wire
